// File: rtl/wvtt_pkg.sv
// Shared types, character codes and time constants for the cue stream parser.
package wvtt_pkg;

   localparam int unsigned OUT_TIME_W  = 40;
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned RSP_DEPTH   = 4;

   localparam logic [7:0] CH_W     = 8'h57;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [21:0] MS_HOUR = 22'd3600000;
   localparam logic [21:0] MS_MIN  = 22'd60000;
   localparam logic [21:0] MS_SEC  = 22'd1000;
   localparam logic [3:0]  TENS_LIMIT = 4'd6;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_TEXT    = 2'd1,
      KIND_COMMIT  = 2'd2,
      KIND_DISCARD = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PART_HOUR = 2'd0,
      PART_MIN  = 2'd1,
      PART_SEC  = 2'd2,
      PART_MS   = 2'd3
   } part_type;

   typedef struct packed {
      logic advance;
      logic drop;
   } tu_ctrl_type;

   typedef struct packed {
      kind_type               kind;
      logic [OUT_TIME_W-1:0]  start_time;
      logic [OUT_TIME_W-1:0]  stop_time;
      logic [7:0]             text_byte;
      logic                   last_of_run;
   } rsp_item_type;

   function automatic logic is_digit(logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

endpackage

// File: rtl/wvtt_time_unit.sv
// Saturating millisecond accumulator step for one byte of a time stamp.
module wvtt_time_unit #(
   parameter int unsigned TIME_BITS = 40
) (
   input  wvtt_pkg::part_type      part,
   input  logic                    is_end,
   input  logic [7:0]              ch,
   input  logic [7:0]              prev,
   input  logic [7:0]              prev2,
   input  logic [TIME_BITS-1:0]    acc,
   output logic [TIME_BITS-1:0]    acc_out,
   output wvtt_pkg::tu_ctrl_type   ctrl
);

   localparam logic [TIME_BITS-1:0] TIME_MAX   = {TIME_BITS{1'b1}};
   localparam logic [TIME_BITS-1:0] TEN_LIMIT  = TIME_MAX / 10;
   localparam logic [TIME_BITS-1:0] HOUR_LIMIT = TIME_MAX / wvtt_pkg::MS_HOUR;
   // hour counts above HOUR_LIMIT saturate, so only the low HOUR_W bits feed the product
   localparam int unsigned HOUR_W = TIME_BITS - 21;

   logic [3:0]           d_c;
   logic [3:0]           d_l;
   logic [3:0]           d_ll;
   logic [TIME_BITS+3:0] m10;
   logic [TIME_BITS:0]   hour_sum;
   logic [TIME_BITS-1:0] acc_digit;
   logic [TIME_BITS:0]   hour_prod;
   logic [TIME_BITS-1:0] acc_hour;
   logic [6:0]           val2;
   logic [9:0]           val3;
   logic [21:0]          inc;
   logic [TIME_BITS:0]   add_sum;
   logic [TIME_BITS-1:0] acc_add;
   logic                 sep_skip;
   logic                 dot_skip;

   assign d_c  = ch[3:0];
   assign d_l  = prev[3:0];
   assign d_ll = prev2[3:0];

   assign m10       = ({4'b0, acc} << 3) + ({4'b0, acc} << 1);
   assign hour_sum  = {1'b0, m10[TIME_BITS-1:0]} + (TIME_BITS+1)'(d_c);
   assign acc_digit = ((acc > TEN_LIMIT) || hour_sum[TIME_BITS]) ?
                      TIME_MAX : hour_sum[TIME_BITS-1:0];

   assign hour_prod = (TIME_BITS+1)'(acc[HOUR_W-1:0]) * (TIME_BITS+1)'(wvtt_pkg::MS_HOUR);
   assign acc_hour  = (acc > HOUR_LIMIT) ? TIME_MAX : hour_prod[TIME_BITS-1:0];

   assign val2 = 7'(d_l) * 7'd10 + 7'(d_c);
   assign val3 = 10'(d_ll) * 10'd100 + 10'(d_l) * 10'd10 + 10'(d_c);

   always_comb begin
      case (part)
         wvtt_pkg::PART_MIN: inc = 22'(val2) * wvtt_pkg::MS_MIN;
         wvtt_pkg::PART_SEC: inc = 22'(val2) * wvtt_pkg::MS_SEC;
         wvtt_pkg::PART_MS:  inc = 22'(val3);
         default:            inc = '0;
      endcase
   end

   assign add_sum = {1'b0, acc} + (TIME_BITS+1)'(inc);
   assign acc_add = add_sum[TIME_BITS] ? TIME_MAX : add_sum[TIME_BITS-1:0];

   // separators between fields are stepped over without touching the sum
   assign sep_skip = (prev == wvtt_pkg::CH_COLON) ||
                     (((part == wvtt_pkg::PART_SEC) || is_end) &&
                      (ch == wvtt_pkg::CH_COLON));
   assign dot_skip = (ch == wvtt_pkg::CH_DOT) || (prev == wvtt_pkg::CH_DOT) ||
                     (prev2 == wvtt_pkg::CH_DOT);

   always_comb begin
      acc_out = acc;
      ctrl    = '0;
      case (part)
         wvtt_pkg::PART_HOUR: begin
            if (wvtt_pkg::is_digit(ch)) begin
               acc_out = acc_digit;
            end else if (ch == wvtt_pkg::CH_COLON) begin
               acc_out      = acc_hour;
               ctrl.advance = 1'b1;
            end else begin
               ctrl.drop = 1'b1;
            end
         end
         wvtt_pkg::PART_MIN, wvtt_pkg::PART_SEC: begin
            if (!sep_skip) begin
               if (wvtt_pkg::is_digit(prev) && wvtt_pkg::is_digit(ch)) begin
                  if (d_l >= wvtt_pkg::TENS_LIMIT) begin
                     ctrl.drop = 1'b1;
                  end else begin
                     acc_out      = acc_add;
                     ctrl.advance = 1'b1;
                  end
               end else begin
                  ctrl.drop = 1'b1;
               end
            end
         end
         wvtt_pkg::PART_MS: begin
            if (!dot_skip) begin
               if (wvtt_pkg::is_digit(prev2) && wvtt_pkg::is_digit(prev) &&
                   wvtt_pkg::is_digit(ch)) begin
                  acc_out      = acc_add;
                  ctrl.advance = 1'b1;
               end else begin
                  ctrl.drop = 1'b1;
               end
            end
         end
         default: begin
            acc_out = acc;
         end
      endcase
   end

endmodule

// File: rtl/wvtt_rsp_fifo.sv
// Result queue: takes up to three results per cycle, hands out one per transaction.
module wvtt_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_count,
   input  wvtt_pkg::rsp_item_type push_items [wvtt_pkg::MAX_RESULTS],
   output logic                   room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output wvtt_pkg::rsp_item_type out_item
);

   localparam int unsigned PTR_W = $clog2(wvtt_pkg::RSP_DEPTH);

   wvtt_pkg::rsp_item_type mem_ff [wvtt_pkg::RSP_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         count_ff, count_in;
   logic [PTR_W-1:0]       wr_sel [wvtt_pkg::RSP_DEPTH];
   logic                   wr_en  [wvtt_pkg::RSP_DEPTH];
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= (PTR_W+1)'(wvtt_pkg::RSP_DEPTH - wvtt_pkg::MAX_RESULTS));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + (PTR_W+1)'(push_count) - (PTR_W+1)'(pop);

   always_comb begin
      for (int e = 0; e < wvtt_pkg::RSP_DEPTH; e++) begin
         wr_sel[e] = PTR_W'(e) - wr_ptr_ff;
         wr_en[e]  = (wr_sel[e] < PTR_W'(push_count));
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < wvtt_pkg::RSP_DEPTH; e++) begin
         if (wr_en[e]) begin
            mem_ff[e] <= push_items[wr_sel[e]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/webvtt_cue_stream_parser.sv
// Cue stream parser top level: byte decoder, time accumulators and result queue.
// Results of an accepted byte are written into the registered result queue and leave on rsp_ in order.
// Throughput: one byte per cycle while the 4-entry result queue holds at most one
// entry and so has room for three results; otherwise req_ready is held low, however
// many results the byte yields, until rsp_ has taken enough results from the queue.
// Reset clears the decoder to header search and empties the result queue.
module webvtt_cue_stream_parser #(
   parameter int unsigned TIME_BITS = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_is_final,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [39:0] rsp_start_time,
   output logic [39:0] rsp_stop_time,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_last_of_run
);

   typedef enum logic [13:0] {
      M_FIND_HDR = 14'b00000000000001,
      M_READ_HDR = 14'b00000000000010,
      M_FIND_TS  = 14'b00000000000100,
      M_S_HOUR   = 14'b00000000001000,
      M_S_MIN    = 14'b00000000010000,
      M_S_SEC    = 14'b00000000100000,
      M_S_MS     = 14'b00000001000000,
      M_CONN     = 14'b00000010000000,
      M_E_HOUR   = 14'b00000100000000,
      M_E_MIN    = 14'b00001000000000,
      M_E_SEC    = 14'b00010000000000,
      M_E_MS     = 14'b00100000000000,
      M_SKIP     = 14'b01000000000000,
      M_TEXT     = 14'b10000000000000
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [7:0]             prev_ff, prev_in;
   logic [7:0]             prev2_ff, prev2_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic [TIME_BITS-1:0]   stop_ff, stop_in;
   logic                   held_ff, held_in;
   logic                   text_ff, text_in;

   logic                   req_fire;
   wvtt_pkg::part_type     tu_part;
   logic                   tu_end;
   logic [TIME_BITS-1:0]   tu_acc;
   logic [TIME_BITS-1:0]   tu_acc_out;
   wvtt_pkg::tu_ctrl_type  tu_ctrl;
   mode_type               adv_mode;
   logic                   take_time;
   logic                   hdr_pair;
   logic                   conn_pair;

   wvtt_pkg::rsp_item_type slot [wvtt_pkg::MAX_RESULTS];
   logic [1:0]             n_res;
   logic [1:0]             push_count;
   logic                   fifo_room;
   wvtt_pkg::rsp_item_type rsp_item;

   function automatic wvtt_pkg::rsp_item_type make_item(
      wvtt_pkg::kind_type   kind,
      logic [TIME_BITS-1:0] st,
      logic [TIME_BITS-1:0] sp,
      logic [7:0]           b
   );
      wvtt_pkg::rsp_item_type item;
      item.kind        = kind;
      item.start_time  = wvtt_pkg::OUT_TIME_W'(st);
      item.stop_time   = wvtt_pkg::OUT_TIME_W'(sp);
      item.text_byte   = b;
      item.last_of_run = 1'b0;
      return item;
   endfunction

   assign req_ready = fifo_room;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      case (mode_ff)
         M_S_MIN, M_E_MIN: tu_part = wvtt_pkg::PART_MIN;
         M_S_SEC, M_E_SEC: tu_part = wvtt_pkg::PART_SEC;
         M_S_MS, M_E_MS:   tu_part = wvtt_pkg::PART_MS;
         default:          tu_part = wvtt_pkg::PART_HOUR;
      endcase
   end

   assign tu_end = (mode_ff == M_E_HOUR) || (mode_ff == M_E_MIN) ||
                   (mode_ff == M_E_SEC) || (mode_ff == M_E_MS);
   assign tu_acc = tu_end ? stop_ff : start_ff;

   always_comb begin
      case (mode_ff)
         M_S_HOUR: adv_mode = M_S_MIN;
         M_S_MIN:  adv_mode = M_S_SEC;
         M_S_SEC:  adv_mode = M_S_MS;
         M_S_MS:   adv_mode = M_CONN;
         M_E_HOUR: adv_mode = M_E_MIN;
         M_E_MIN:  adv_mode = M_E_SEC;
         M_E_SEC:  adv_mode = M_E_MS;
         M_E_MS:   adv_mode = M_SKIP;
         default:  adv_mode = mode_ff;
      endcase
   end

   wvtt_time_unit #(
      .TIME_BITS (TIME_BITS)
   ) u_time (
      .part    (tu_part),
      .is_end  (tu_end),
      .ch      (req_ch),
      .prev    (prev_ff),
      .prev2   (prev2_ff),
      .acc     (tu_acc),
      .acc_out (tu_acc_out),
      .ctrl    (tu_ctrl)
   );

   assign hdr_pair = ((prev_ff == wvtt_pkg::CH_W) && (req_ch == wvtt_pkg::CH_E)) ||
                     ((prev_ff == wvtt_pkg::CH_E) && (req_ch == wvtt_pkg::CH_B)) ||
                     ((prev_ff == wvtt_pkg::CH_B) && (req_ch == wvtt_pkg::CH_V)) ||
                     ((prev_ff == wvtt_pkg::CH_V) && (req_ch == wvtt_pkg::CH_T)) ||
                     ((prev_ff == wvtt_pkg::CH_T) && (req_ch == wvtt_pkg::CH_T));

   assign conn_pair = (wvtt_pkg::is_digit(prev_ff) && (req_ch == wvtt_pkg::CH_SPACE)) ||
                      ((prev_ff == wvtt_pkg::CH_SPACE) && (req_ch == wvtt_pkg::CH_DASH)) ||
                      ((prev_ff == wvtt_pkg::CH_DASH) && (req_ch == wvtt_pkg::CH_DASH)) ||
                      ((prev_ff == wvtt_pkg::CH_DASH) && (req_ch == wvtt_pkg::CH_GT));

   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      stop_in   = stop_ff;
      held_in   = held_ff;
      text_in   = text_ff;
      prev2_in  = prev_ff;
      prev_in   = req_ch;
      take_time = 1'b0;
      n_res     = '0;
      for (int k = 0; k < wvtt_pkg::MAX_RESULTS; k++) begin
         slot[k] = '0;
      end

      case (mode_ff)
         M_FIND_HDR: begin
            if (req_ch == wvtt_pkg::CH_W) mode_in = M_READ_HDR;
         end
         M_READ_HDR: begin
            if (hdr_pair) begin
               mode_in = M_READ_HDR;
            end else if ((prev_ff == wvtt_pkg::CH_T) && (req_ch == wvtt_pkg::CH_LF)) begin
               mode_in = M_FIND_TS;
            end else begin
               mode_in = M_FIND_HDR;
            end
         end
         M_FIND_TS: begin
            if ((prev_ff == wvtt_pkg::CH_LF) && wvtt_pkg::is_digit(req_ch)) begin
               mode_in   = M_S_HOUR;
               take_time = 1'b1;
            end
         end
         M_S_HOUR, M_S_MIN, M_S_SEC, M_S_MS,
         M_E_HOUR, M_E_MIN, M_E_SEC, M_E_MS: begin
            take_time = 1'b1;
         end
         M_CONN: begin
            if (conn_pair) begin
               mode_in = M_CONN;
            end else if ((prev_ff == wvtt_pkg::CH_GT) && (req_ch == wvtt_pkg::CH_SPACE)) begin
               mode_in = M_E_HOUR;
            end else begin
               start_in = '0;
               stop_in  = '0;
               mode_in  = M_FIND_TS;
            end
         end
         M_SKIP: begin
            if (req_ch == wvtt_pkg::CH_LF) begin
               mode_in = M_TEXT;
               slot[0] = make_item(wvtt_pkg::KIND_HEADER, start_ff, stop_ff, 8'h00);
               n_res   = 2'd1;
            end
         end
         M_TEXT: begin
            if ((req_ch == wvtt_pkg::CH_LF) && (prev_ff == wvtt_pkg::CH_LF)) begin
               slot[0]  = make_item((stop_ff > start_ff) ? wvtt_pkg::KIND_COMMIT :
                                    wvtt_pkg::KIND_DISCARD, start_ff, stop_ff, 8'h00);
               n_res    = 2'd1;
               held_in  = 1'b0;
               text_in  = 1'b0;
               start_in = '0;
               stop_in  = '0;
               mode_in  = M_FIND_TS;
            end else begin
               // release the held newline now that the line is not blank
               if (held_ff) begin
                  slot[n_res] = make_item(wvtt_pkg::KIND_TEXT, '0, '0, wvtt_pkg::CH_LF);
                  n_res       = n_res + 2'd1;
                  held_in     = 1'b0;
               end
               if (req_ch == wvtt_pkg::CH_LF) begin
                  held_in = 1'b1;
               end else begin
                  slot[n_res] = make_item(wvtt_pkg::KIND_TEXT, '0, '0, req_ch);
                  n_res       = n_res + 2'd1;
               end
               text_in = 1'b1;
            end
         end
         default: begin
            mode_in = M_FIND_HDR;
         end
      endcase

      if (take_time) begin
         if (tu_ctrl.drop) begin
            start_in = '0;
            stop_in  = '0;
            mode_in  = M_FIND_TS;
         end else begin
            if (tu_end) stop_in = tu_acc_out;
            else        start_in = tu_acc_out;
            if (tu_ctrl.advance) mode_in = adv_mode;
         end
      end

      // end of file: flush a cue with text, drop the held newline, return to reset
      if (req_is_final) begin
         if (text_in) begin
            slot[n_res] = make_item(wvtt_pkg::KIND_COMMIT, start_in, stop_in, 8'h00);
            n_res       = n_res + 2'd1;
         end
         mode_in  = M_FIND_HDR;
         prev_in  = '0;
         prev2_in = '0;
         start_in = '0;
         stop_in  = '0;
         held_in  = 1'b0;
         text_in  = 1'b0;
      end

      if (n_res != '0) slot[n_res - 2'd1].last_of_run = 1'b1;
   end

   assign push_count = req_fire ? n_res : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_FIND_HDR;
         prev_ff  <= '0;
         prev2_ff <= '0;
         start_ff <= '0;
         stop_ff  <= '0;
         held_ff  <= 1'b0;
         text_ff  <= 1'b0;
      end else if (req_fire) begin
         mode_ff  <= mode_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
         start_ff <= start_in;
         stop_ff  <= stop_in;
         held_ff  <= held_in;
         text_ff  <= text_in;
      end
   end

   wvtt_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_items (slot),
      .room       (fifo_room),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_item   (rsp_item)
   );

   assign rsp_kind        = rsp_item.kind;
   assign rsp_start_time  = rsp_item.start_time;
   assign rsp_stop_time   = rsp_item.stop_time;
   assign rsp_text_byte   = rsp_item.text_byte;
   assign rsp_last_of_run = rsp_item.last_of_run;

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_is_final) |=> (mode_ff == M_FIND_HDR) && !text_ff && !held_ff)
      else $error("state not cleared after final byte");

   a_text_in_cue: assert property (@(posedge clock) disable iff (reset)
      text_ff |-> (mode_ff == M_TEXT))
      else $error("cue text flag set outside cue text");

   a_held_needs_text: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> text_ff)
      else $error("newline held without cue text");

   a_text_no_times: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == wvtt_pkg::KIND_TEXT)) |->
      ((rsp_start_time == '0) && (rsp_stop_time == '0)))
      else $error("text result carries times");

endmodule
